// ----- rtl/pci_pkg.sv -----
package pci_pkg;

    localparam int COLOR_W     = 32;
    localparam int CHAN_W      = 8;
    localparam int INDEX_OUT_W = 8;
    localparam int USED_OUT_W  = 9;

    // Control that rides along with a pixel down the cell chain
    typedef struct packed {
        logic active;
        logic hit;
        logic added;
    } t_flags;

endpackage

// ----- rtl/pci_cell.sv -----
module pci_cell #(
    parameter int IDX_W   = 8,
    parameter int CNT_W   = 9,
    parameter int CELL_ID = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pci_pkg::t_flags            i_flags,
    input  logic [pci_pkg::COLOR_W-1:0] i_color,
    input  logic [CNT_W-1:0]           i_count,
    input  logic [IDX_W-1:0]           i_idx,
    output pci_pkg::t_flags            o_flags,
    output logic [pci_pkg::COLOR_W-1:0] o_color,
    output logic [CNT_W-1:0]           o_count,
    output logic [IDX_W-1:0]           o_idx
);

    logic [pci_pkg::COLOR_W-1:0] r_entry;
    pci_pkg::t_flags             r_flags;
    pci_pkg::t_flags             n_flags;
    logic [pci_pkg::COLOR_W-1:0] r_color;
    logic [CNT_W-1:0]            r_count;
    logic [IDX_W-1:0]            r_idx;
    logic [IDX_W-1:0]            n_idx;
    logic                        in_use;
    logic                        at_tail;
    logic                        match;
    logic                        do_write;

    assign in_use   = CNT_W'(CELL_ID) < i_count;
    assign at_tail  = CNT_W'(CELL_ID) == i_count;
    assign match    = in_use && (r_entry == i_color);
    assign do_write = i_flags.active && !i_flags.hit && !match && at_tail;

    always_comb begin
        n_flags = i_flags;
        n_idx   = i_idx;
        if (i_flags.active && !i_flags.hit) begin
            if (match) begin
                n_flags.hit = 1'b1;
                n_idx       = IDX_W'(CELL_ID);
            end else if (at_tail) begin
                n_flags.hit   = 1'b1;
                n_flags.added = 1'b1;
                n_idx         = IDX_W'(CELL_ID);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_entry <= i_color;
        end
        r_color <= i_color;
        r_count <= i_count;
        r_idx   <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
    end

    assign o_flags = r_flags;
    assign o_color = r_color;
    assign o_count = r_count;
    assign o_idx   = r_idx;

endmodule

// ----- rtl/palette_color_indexer_core.sv -----
// Exact-match palette builder. Each pixel walks a chain of PALETTE_ENTRIES
// cells, one cell per cycle; each cell holds one palette color. The result
// strobe o_valid comes from the chain tail once the pixel has passed the
// register of every cell; busy stays high from the accepting edge through
// the strobe cycle, so a new pixel is taken only once the last one's
// result is out. The receiver cannot stall: each result is on the o_ ports
// for exactly the one cycle that o_valid is high and must be captured then.
module palette_color_indexer_core #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_first_of_image,
    input  logic [pci_pkg::CHAN_W-1:0]        i_red,
    input  logic [pci_pkg::CHAN_W-1:0]        i_green,
    input  logic [pci_pkg::CHAN_W-1:0]        i_blue,
    input  logic [pci_pkg::CHAN_W-1:0]        i_alpha,
    output logic                              o_valid,
    output logic [pci_pkg::INDEX_OUT_W-1:0]   o_color_index,
    output logic                              o_new_entry,
    output logic                              o_overflow,
    output logic [pci_pkg::USED_OUT_W-1:0]    o_colors_used
);

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);

    pci_pkg::t_flags             chain_flags [0:PALETTE_ENTRIES];
    logic [pci_pkg::COLOR_W-1:0] chain_color [0:PALETTE_ENTRIES];
    logic [CNT_W-1:0]            chain_count [0:PALETTE_ENTRIES];
    logic [IDX_W-1:0]            chain_idx   [0:PALETTE_ENTRIES];

    logic             r_busy;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             accept;
    pci_pkg::t_flags  tail_flags;
    logic [CNT_W-1:0] tail_count;
    logic [IDX_W-1:0] tail_idx;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    // Inject the pixel into the head of the chain
    always_comb begin
        chain_flags[0]        = '0;
        chain_flags[0].active = accept;
        chain_color[0]        = {i_red, i_green, i_blue, i_alpha};
        chain_count[0]        = i_first_of_image ? '0 : r_count;
        chain_idx[0]          = '0;
    end

    for (genvar g = 0; g < PALETTE_ENTRIES; g++) begin : g_cell
        pci_cell #(
            .IDX_W   (IDX_W),
            .CNT_W   (CNT_W),
            .CELL_ID (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_flags (chain_flags[g]),
            .i_color (chain_color[g]),
            .i_count (chain_count[g]),
            .i_idx   (chain_idx[g]),
            .o_flags (chain_flags[g+1]),
            .o_color (chain_color[g+1]),
            .o_count (chain_count[g+1]),
            .o_idx   (chain_idx[g+1])
        );
    end

    assign tail_flags = chain_flags[PALETTE_ENTRIES];
    assign tail_count = chain_count[PALETTE_ENTRIES];
    assign tail_idx   = chain_idx[PALETTE_ENTRIES];

    // Count only grows on an append, which happens below the full mark
    assign n_count = tail_count + CNT_W'(tail_flags.added);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (tail_flags.active) begin
                r_busy <= 1'b0;
            end
            if (tail_flags.active) begin
                r_count <= n_count;
            end
        end
    end

    assign o_valid     = tail_flags.active;
    assign o_new_entry = tail_flags.added;
    assign o_overflow  = !tail_flags.hit;

    if (IDX_W >= pci_pkg::INDEX_OUT_W) begin : g_idx_trunc
        assign o_color_index = tail_flags.hit ? tail_idx[pci_pkg::INDEX_OUT_W-1:0] : '0;
    end else begin : g_idx_ext
        assign o_color_index = tail_flags.hit ?
            {{(pci_pkg::INDEX_OUT_W-IDX_W){1'b0}}, tail_idx} : '0;
    end

    if (CNT_W >= pci_pkg::USED_OUT_W) begin : g_cnt_trunc
        assign o_colors_used = n_count[pci_pkg::USED_OUT_W-1:0];
    end else begin : g_cnt_ext
        assign o_colors_used = {{(pci_pkg::USED_OUT_W-CNT_W){1'b0}}, n_count};
    end

endmodule
